// ----- design/rpc_pkg.sv -----
// Shared constants for the running Pearson correlation core.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package rpc_pkg;

    // default sizing of the core
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;

    // fixed field widths
    localparam int TOT_W     = 16;   // total_count register
    localparam int CKP_W     = 9;    // checkpoint_count register
    localparam int CKNUM_W   = 8;    // checkpoint_number field
    localparam int USED_W    = 16;   // samples_used field
    localparam int CORR_W    = 16;   // correlation field
    localparam int FRAC_BITS = 15;   // Q1.15
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [CORR_W-1:0] CORR_MAX = 16'h7FFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_COUNT      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECKPOINT_COUNT = 1'b1;

    // checkpoint queue and multiplier slicing
    localparam int QUEUE_DEPTH = 4;
    localparam int MUL_CHUNK   = 32;

endpackage

`default_nettype wire

// ----- design/rpc_fifo.sv -----
// Short register queue carrying checkpoint snapshots from front to back.
// Depends on nothing but its parameters.
`default_nettype none

module rpc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/rpc_mul.sv -----
// Sequential signed multiplier: one 32x32 partial product per cycle.
// Depends on rpc_pkg for the chunk width.
`default_nettype none

module rpc_mul #(
    parameter int MW = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [MW-1:0] a,
    input  wire logic signed [MW-1:0] b,
    output logic                      done,
    output logic signed [2*MW-1:0]    p
);

    localparam int CHUNK = rpc_pkg::MUL_CHUNK;
    localparam int CSH   = $clog2(CHUNK);
    localparam int NCH   = (MW + CHUNK - 1) / CHUNK;
    localparam int PAD   = NCH * CHUNK;
    localparam int ACC_W = 2 * PAD;
    localparam int PW    = 2 * MW;
    localparam int IW    = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SHW   = IW + 1;

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_SIGN} mstate_t;

    mstate_t            state_reg;
    logic [PAD-1:0]     am_reg, bm_reg;
    logic               neg_reg;
    logic [IW-1:0]      ia_reg, ib_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic signed [PW-1:0] p_reg;
    logic               done_reg;

    logic [MW-1:0]      a_mag, b_mag;
    logic [CHUNK-1:0]   chunk_a, chunk_b;
    logic [2*CHUNK-1:0] part;
    logic [SHW-1:0]     sh_sum;
    logic [ACC_W-1:0]   part_sh;
    logic               ia_last, ib_last;

    assign a_mag   = a[MW-1] ? MW'(-a) : MW'(a);
    assign b_mag   = b[MW-1] ? MW'(-b) : MW'(b);
    assign chunk_a = am_reg[ia_reg*CHUNK +: CHUNK];
    assign chunk_b = bm_reg[ib_reg*CHUNK +: CHUNK];
    assign part    = chunk_a * chunk_b;
    assign sh_sum  = SHW'(ia_reg) + SHW'(ib_reg);
    assign part_sh = ACC_W'(part) << {sh_sum, {CSH{1'b0}}};
    assign ia_last = (ia_reg == IW'(NCH - 1));
    assign ib_last = (ib_reg == IW'(NCH - 1));
    assign done    = done_reg;
    assign p       = p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            am_reg    <= '0;
            bm_reg    <= '0;
            neg_reg   <= 1'b0;
            ia_reg    <= '0;
            ib_reg    <= '0;
            acc_reg   <= '0;
            p_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                M_IDLE:
                begin
                    if (start)
                    begin
                        am_reg    <= PAD'(a_mag);
                        bm_reg    <= PAD'(b_mag);
                        neg_reg   <= a[MW-1] ^ b[MW-1];
                        ia_reg    <= '0;
                        ib_reg    <= '0;
                        acc_reg   <= '0;
                        state_reg <= M_RUN;
                    end
                end
                M_RUN:
                begin
                    acc_reg <= acc_reg + part_sh;
                    if (ib_last)
                    begin
                        ib_reg <= '0;
                        ia_reg <= ia_reg + 1'b1;
                        if (ia_last)
                        begin
                            state_reg <= M_SIGN;
                        end
                    end
                    else
                    begin
                        ib_reg <= ib_reg + 1'b1;
                    end
                end
                M_SIGN:
                begin
                    p_reg     <= neg_reg ? PW'(-acc_reg) : PW'(acc_reg);
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/rpc_front.sv -----
// Front end: accepts sample pairs, keeps the running sums and counters,
// spots checkpoints and pushes a snapshot. Depends on rpc_pkg.
`default_nettype none

module rpc_front #(
    parameter int SW    = 16,
    parameter int CW    = 16,
    parameter int SUM_W = 32,
    parameter int SQ_W  = 48,
    parameter int NXT_W = 17
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rpc_pkg::CFG_DAT_W-1:0]       cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [SW-1:0]                measured,
    input  wire logic signed [SW-1:0]                estimated,
    input  wire logic                                q_full,
    output logic                                     push,
    output logic [CW-1:0]                            snap_n,
    output logic signed [SUM_W-1:0]                  snap_sa,
    output logic signed [SUM_W-1:0]                  snap_sb,
    output logic signed [SQ_W-1:0]                   snap_saa,
    output logic signed [SQ_W-1:0]                   snap_sbb,
    output logic signed [SQ_W-1:0]                   snap_sab,
    output logic [rpc_pkg::CKNUM_W-1:0]              snap_ck,
    output logic                                     snap_last
);

    localparam int TW  = rpc_pkg::TOT_W;
    localparam int KW  = rpc_pkg::CKP_W;
    localparam int PRW = 2 * SW;
    localparam int DCW = $clog2(TW + 1);

    logic [TW-1:0]          tot_reg;
    logic [KW-1:0]          ckc_reg;
    logic signed [SUM_W-1:0] sa_reg, sb_reg;
    logic signed [SQ_W-1:0] saa_reg, sbb_reg, sab_reg;
    logic [CW-1:0]          pc_reg;
    logic [KW-1:0]          ck_reg;
    logic [NXT_W-1:0]       nxt_reg;
    logic [KW-1:0]          rem_reg;
    logic [TW-1:0]          q0_reg;
    logic [KW-1:0]          r0_reg;
    logic                   div_busy_reg;
    logic [DCW-1:0]         div_cnt_reg;
    logic [TW-1:0]          div_quo_reg;
    logic [KW-1:0]          div_rem_reg;

    logic signed [PRW-1:0]  prod_aa, prod_bb, prod_ab;
    logic signed [SUM_W-1:0] sa_sum, sb_sum;
    logic signed [SQ_W-1:0] saa_sum, sbb_sum, sab_sum;
    logic [CW-1:0]          pc_inc;
    logic                   armed, hit, run_end, accept;
    logic [KW:0]            rem_sum;
    logic                   carry;
    logic [KW-1:0]          rem_step;
    logic [NXT_W-1:0]       nxt_step;
    logic [KW:0]            div_trial;
    logic                   div_ge, div_last;
    logic [KW-1:0]          div_rem_new;
    logic [TW-1:0]          div_quo_new;
    logic [TW-1:0]          tot_new;

    assign prod_aa = measured * measured;
    assign prod_bb = estimated * estimated;
    assign prod_ab = measured * estimated;
    assign sa_sum  = sa_reg + SUM_W'(measured);
    assign sb_sum  = sb_reg + SUM_W'(estimated);
    assign saa_sum = saa_reg + SQ_W'(prod_aa);
    assign sbb_sum = sbb_reg + SQ_W'(prod_bb);
    assign sab_sum = sab_reg + SQ_W'(prod_ab);
    assign pc_inc  = pc_reg + 1'b1;

    assign armed   = (ckc_reg != '0) && (tot_reg != '0) && (TW'(ckc_reg) <= tot_reg);
    assign hit     = armed && (NXT_W'(pc_inc) == nxt_reg);
    assign run_end = (pc_inc == CW'(tot_reg));
    assign in_ready = !div_busy_reg && !q_full;
    assign accept  = in_valid && in_ready;

    // evenly spaced checkpoints: step T/C per checkpoint, carry on remainder
    assign rem_sum  = {1'b0, rem_reg} + {1'b0, r0_reg};
    assign carry    = (rem_sum >= {1'b0, ckc_reg});
    assign rem_step = carry ? KW'(rem_sum - {1'b0, ckc_reg}) : rem_sum[KW-1:0];
    assign nxt_step = nxt_reg + NXT_W'(q0_reg) + NXT_W'(carry);

    // restoring divider, one quotient bit a cycle
    assign div_trial   = {div_rem_reg, div_quo_reg[TW-1]};
    assign div_ge      = (div_trial >= {1'b0, ckc_reg});
    assign div_rem_new = div_ge ? KW'(div_trial - {1'b0, ckc_reg}) : div_trial[KW-1:0];
    assign div_quo_new = {div_quo_reg[TW-2:0], div_ge};
    assign div_last    = (div_cnt_reg == DCW'(TW - 1));
    assign tot_new     = (cfg_index == rpc_pkg::CFG_TOTAL_COUNT) ? cfg_data : tot_reg;

    assign push      = accept && hit;
    assign snap_n    = pc_inc;
    assign snap_sa   = sa_sum;
    assign snap_sb   = sb_sum;
    assign snap_saa  = saa_sum;
    assign snap_sbb  = sbb_sum;
    assign snap_sab  = sab_sum;
    assign snap_ck   = ck_reg[rpc_pkg::CKNUM_W-1:0];
    assign snap_last = (KW'(ck_reg + 1'b1) == ckc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg      <= TW'(1);
            ckc_reg      <= KW'(1);
            sa_reg       <= '0;
            sb_reg       <= '0;
            saa_reg      <= '0;
            sbb_reg      <= '0;
            sab_reg      <= '0;
            pc_reg       <= '0;
            ck_reg       <= '0;
            nxt_reg      <= NXT_W'(1);
            rem_reg      <= '0;
            q0_reg       <= TW'(1);
            r0_reg       <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_quo_reg  <= '0;
            div_rem_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rpc_pkg::CFG_TOTAL_COUNT:      tot_reg <= cfg_data;
                rpc_pkg::CFG_CHECKPOINT_COUNT: ckc_reg <= cfg_data[KW-1:0];
                default:                       tot_reg <= tot_reg;
            endcase
            sa_reg       <= '0;
            sb_reg       <= '0;
            saa_reg      <= '0;
            sbb_reg      <= '0;
            sab_reg      <= '0;
            pc_reg       <= '0;
            ck_reg       <= '0;
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
            div_quo_reg  <= tot_new;
            div_rem_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            div_quo_reg <= div_quo_new;
            div_rem_reg <= div_rem_new;
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (div_last)
            begin
                div_busy_reg <= 1'b0;
                q0_reg       <= div_quo_new;
                r0_reg       <= div_rem_new;
                nxt_reg      <= NXT_W'(div_quo_new);
                rem_reg      <= div_rem_new;
            end
        end
        else if (accept)
        begin
            if (run_end)
            begin
                sa_reg  <= '0;
                sb_reg  <= '0;
                saa_reg <= '0;
                sbb_reg <= '0;
                sab_reg <= '0;
                pc_reg  <= '0;
                ck_reg  <= '0;
                nxt_reg <= NXT_W'(q0_reg);
                rem_reg <= r0_reg;
            end
            else
            begin
                sa_reg  <= sa_sum;
                sb_reg  <= sb_sum;
                saa_reg <= saa_sum;
                sbb_reg <= sbb_sum;
                sab_reg <= sab_sum;
                pc_reg  <= pc_inc;
                if (hit)
                begin
                    ck_reg  <= ck_reg + 1'b1;
                    nxt_reg <= nxt_step;
                    rem_reg <= rem_step;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/rpc_back.sv -----
// Back end: turns a checkpoint snapshot into a Q1.15 coefficient and
// holds the output register. Depends on rpc_pkg and rpc_mul.
`default_nettype none

module rpc_back #(
    parameter int CW    = 16,
    parameter int SUM_W = 32,
    parameter int SQ_W  = 48,
    parameter int MW    = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_empty,
    output logic                                   pop,
    input  wire logic [CW-1:0]                     snap_n,
    input  wire logic signed [SUM_W-1:0]           snap_sa,
    input  wire logic signed [SUM_W-1:0]           snap_sb,
    input  wire logic signed [SQ_W-1:0]            snap_saa,
    input  wire logic signed [SQ_W-1:0]            snap_sbb,
    input  wire logic signed [SQ_W-1:0]            snap_sab,
    input  wire logic [rpc_pkg::CKNUM_W-1:0]       snap_ck,
    input  wire logic                              snap_last,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [rpc_pkg::CORR_W-1:0]             out_corr,
    output logic [rpc_pkg::CKNUM_W-1:0]            out_ck,
    output logic [rpc_pkg::USED_W-1:0]             out_used,
    output logic                                   out_last
);

    localparam int PW = 2 * MW;
    localparam int XW = PW + 32;
    localparam int QW = rpc_pkg::FRAC_BITS + 1;
    localparam int JW = $clog2(QW);
    localparam int RSH = 2 * rpc_pkg::FRAC_BITS;

    typedef enum logic [2:0] {
        B_IDLE, B_ISSUE, B_WAIT, B_CHECK, B_SRCH_A, B_SRCH_B, B_DONE
    } bstate_t;

    typedef enum logic [2:0] {
        OP_NAB, OP_AB, OP_NAA, OP_AA, OP_NBB, OP_BB, OP_VAVB, OP_MAG2
    } op_t;

    bstate_t                state_reg;
    op_t                    op_reg, op_next;
    logic [CW-1:0]          n_reg;
    logic signed [SUM_W-1:0] sa_reg, sb_reg;
    logic signed [SQ_W-1:0] saa_reg, sbb_reg, sab_reg;
    logic [rpc_pkg::CKNUM_W-1:0] ck_reg;
    logic                   last_reg;
    logic signed [MW-1:0]   num_reg, va_reg, vb_reg, mag_reg;
    logic                   neg_reg;
    logic [PW-1:0]          p_reg, r_reg;
    logic [XW-1:0]          s_reg, t_reg, cand_reg;
    logic [JW-1:0]          j_reg;
    logic [QW-1:0]          q_reg;
    logic                   ov_reg;
    logic [rpc_pkg::CORR_W-1:0]  corr_reg;
    logic [rpc_pkg::CKNUM_W-1:0] ocki_reg;
    logic [rpc_pkg::USED_W-1:0]  used_reg;
    logic                   olast_reg;

    logic signed [MW-1:0]   op_a, op_b, n_ext;
    logic                   mul_start, mul_done;
    logic signed [PW-1:0]   mul_p;
    logic signed [MW-1:0]   p_lo;
    logic [XW-1:0]          cand_next, r_cmp, t_step;
    logic [JW:0]            j_inc;
    logic [rpc_pkg::CORR_W-1:0] q_sat, corr_val;
    logic                   out_free;
    logic                   out_load;

    assign n_ext     = $signed(MW'(n_reg));
    assign p_lo      = mul_p[MW-1:0];
    assign mul_start = (state_reg == B_ISSUE);
    assign pop       = (state_reg == B_IDLE) && !q_empty;
    assign out_free  = !ov_reg || out_ready;
    assign out_load  = (state_reg == B_DONE) && out_free;

    always_comb
    begin
        unique case (op_reg)
            OP_NAB:  begin op_a = n_ext;          op_b = MW'(sab_reg); op_next = OP_AB;   end
            OP_AB:   begin op_a = MW'(sa_reg);    op_b = MW'(sb_reg);  op_next = OP_NAA;  end
            OP_NAA:  begin op_a = n_ext;          op_b = MW'(saa_reg); op_next = OP_AA;   end
            OP_AA:   begin op_a = MW'(sa_reg);    op_b = MW'(sa_reg);  op_next = OP_NBB;  end
            OP_NBB:  begin op_a = n_ext;          op_b = MW'(sbb_reg); op_next = OP_BB;   end
            OP_BB:   begin op_a = MW'(sb_reg);    op_b = MW'(sb_reg);  op_next = OP_VAVB; end
            OP_VAVB: begin op_a = va_reg;         op_b = vb_reg;       op_next = OP_MAG2; end
            OP_MAG2: begin op_a = mag_reg;        op_b = mag_reg;      op_next = OP_NAB;  end
            default: begin op_a = '0;             op_b = '0;           op_next = OP_NAB;  end
        endcase
    end

    // trial q + 2^j: (q + 2^j)^2 P = q^2 P + 2^(j+1) qP + 2^(2j) P
    assign j_inc     = {1'b0, j_reg} + 1'b1;
    assign cand_next = s_reg + (t_reg << j_inc) + (XW'(p_reg) << {j_reg, 1'b0});
    assign t_step    = t_reg + (XW'(p_reg) << j_reg);
    assign r_cmp     = XW'(r_reg) << RSH;

    assign q_sat    = (q_reg > QW'(rpc_pkg::CORR_MAX)) ? rpc_pkg::CORR_MAX
                                                       : rpc_pkg::CORR_W'(q_reg);
    assign corr_val = neg_reg ? rpc_pkg::CORR_W'(-q_sat) : q_sat;

    assign out_valid = ov_reg;
    assign out_corr  = corr_reg;
    assign out_ck    = ocki_reg;
    assign out_used  = used_reg;
    assign out_last  = olast_reg;

    rpc_mul #(.MW(MW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            op_reg    <= OP_NAB;
            ov_reg    <= 1'b0;
            n_reg     <= '0;
            sa_reg    <= '0;
            sb_reg    <= '0;
            saa_reg   <= '0;
            sbb_reg   <= '0;
            sab_reg   <= '0;
            ck_reg    <= '0;
            last_reg  <= 1'b0;
            num_reg   <= '0;
            va_reg    <= '0;
            vb_reg    <= '0;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            p_reg     <= '0;
            r_reg     <= '0;
            s_reg     <= '0;
            t_reg     <= '0;
            cand_reg  <= '0;
            j_reg     <= '0;
            q_reg     <= '0;
            corr_reg  <= '0;
            ocki_reg  <= '0;
            used_reg  <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        n_reg     <= snap_n;
                        sa_reg    <= snap_sa;
                        sb_reg    <= snap_sb;
                        saa_reg   <= snap_saa;
                        sbb_reg   <= snap_sbb;
                        sab_reg   <= snap_sab;
                        ck_reg    <= snap_ck;
                        last_reg  <= snap_last;
                        op_reg    <= OP_NAB;
                        state_reg <= B_ISSUE;
                    end
                end
                B_ISSUE:
                begin
                    state_reg <= B_WAIT;
                end
                B_WAIT:
                begin
                    if (mul_done)
                    begin
                        unique case (op_reg)
                            OP_NAB:  num_reg <= p_lo;
                            OP_AB:   num_reg <= num_reg - p_lo;
                            OP_NAA:  va_reg  <= p_lo;
                            OP_AA:   va_reg  <= va_reg - p_lo;
                            OP_NBB:  vb_reg  <= p_lo;
                            OP_BB:   vb_reg  <= vb_reg - p_lo;
                            OP_VAVB: p_reg   <= PW'(mul_p);
                            OP_MAG2: r_reg   <= PW'(mul_p);
                            default: p_reg   <= p_reg;
                        endcase
                        if (op_reg == OP_BB)
                        begin
                            state_reg <= B_CHECK;
                        end
                        else if (op_reg == OP_MAG2)
                        begin
                            s_reg     <= '0;
                            t_reg     <= '0;
                            q_reg     <= '0;
                            j_reg     <= JW'(QW - 1);
                            state_reg <= B_SRCH_A;
                        end
                        else
                        begin
                            op_reg    <= op_next;
                            state_reg <= B_ISSUE;
                        end
                    end
                end
                B_CHECK:
                begin
                    // zero numerator or degenerate variance reads as 0
                    if (num_reg == '0 || va_reg == '0 || va_reg[MW-1] ||
                        vb_reg == '0 || vb_reg[MW-1])
                    begin
                        q_reg     <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        neg_reg   <= num_reg[MW-1];
                        mag_reg   <= num_reg[MW-1] ? -num_reg : num_reg;
                        op_reg    <= OP_VAVB;
                        state_reg <= B_ISSUE;
                    end
                end
                B_SRCH_A:
                begin
                    cand_reg  <= cand_next;
                    state_reg <= B_SRCH_B;
                end
                B_SRCH_B:
                begin
                    if (cand_reg <= r_cmp)
                    begin
                        s_reg        <= cand_reg;
                        t_reg        <= t_step;
                        q_reg[j_reg] <= 1'b1;
                    end
                    if (j_reg == '0)
                    begin
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= B_SRCH_A;
                    end
                end
                B_DONE:
                begin
                    if (out_free)
                    begin
                        corr_reg  <= corr_val;
                        ocki_reg  <= ck_reg;
                        used_reg  <= rpc_pkg::USED_W'(n_reg);
                        olast_reg <= last_reg;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/running_pearson_correlation_core.sv -----
// Running Pearson correlation core: front end, snapshot queue, back end.
// Throughput: one sample pair per cycle while the T/C divider is idle; the time a
//   checkpoint result takes after its pair is set by the shared multiplier
//   (NCH = 32-bit slices of the 64-bit multiplier operands) and the 16-step root
//   search. Up to 4 snapshots queue up; input stalls while the queue is full.
// A configuration write stalls input while the T/C divider runs.
// Reset (rst_n low, asynchronous): total_count = checkpoint_count = 1, sums clear.
// Depends on rpc_pkg, rpc_front, rpc_fifo, rpc_mul, rpc_back.
`default_nettype none

module running_pearson_correlation_core #(
    parameter int SAMPLE_WIDTH = rpc_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH  = rpc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [rpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rpc_pkg::CFG_DAT_W-1:0]      cfg_data,
    // sample pair stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: measured_value, estimated_value (low bits first), zero pad
    input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: correlation[15:0], checkpoint_number[23:16], samples_used[39:24]
    output logic [39:0]                             m_tdata,
    // m_tlast: run_done
    output logic                                    m_tlast
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = COUNT_WIDTH;
    localparam int SUM_W = SW + CW;
    localparam int SQ_W  = 2 * SW + CW;
    localparam int MW    = 2 * (SW + CW);
    localparam int NXT_W = ((CW > rpc_pkg::TOT_W) ? CW : rpc_pkg::TOT_W) + 1;
    localparam int KN    = rpc_pkg::CKNUM_W;
    // snapshot layout: n, sa, sb, saa, sbb, sab, ck, last (low bits first)
    localparam int O_SA  = CW;
    localparam int O_SB  = O_SA + SUM_W;
    localparam int O_SAA = O_SB + SUM_W;
    localparam int O_SBB = O_SAA + SQ_W;
    localparam int O_SAB = O_SBB + SQ_W;
    localparam int O_CK  = O_SAB + SQ_W;
    localparam int O_LST = O_CK + KN;
    localparam int SNAP_W = O_LST + 1;

    logic                   q_full, q_empty, push, pop;
    logic [SNAP_W-1:0]      wr_snap, rd_snap;

    logic [CW-1:0]          f_n;
    logic signed [SUM_W-1:0] f_sa, f_sb;
    logic signed [SQ_W-1:0] f_saa, f_sbb, f_sab;
    logic [KN-1:0]          f_ck;
    logic                   f_last;

    logic [rpc_pkg::CORR_W-1:0] o_corr;
    logic [KN-1:0]              o_ck;
    logic [rpc_pkg::USED_W-1:0] o_used;

    // accept, accumulate and detect checkpoints
    rpc_front #(
        .SW(SW), .CW(CW), .SUM_W(SUM_W), .SQ_W(SQ_W), .NXT_W(NXT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .measured  ($signed(s_tdata[SW-1:0])),
        .estimated ($signed(s_tdata[2*SW-1:SW])),
        .q_full    (q_full),
        .push      (push),
        .snap_n    (f_n),
        .snap_sa   (f_sa),
        .snap_sb   (f_sb),
        .snap_saa  (f_saa),
        .snap_sbb  (f_sbb),
        .snap_sab  (f_sab),
        .snap_ck   (f_ck),
        .snap_last (f_last)
    );

    assign wr_snap = {f_last, f_ck, f_sab, f_sbb, f_saa, f_sb, f_sa, f_n};

    // hold snapshots while the back end works through earlier ones
    rpc_fifo #(
        .WIDTH(SNAP_W), .DEPTH(rpc_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (wr_snap),
        .full    (q_full),
        .rd_en   (pop),
        .rd_data (rd_snap),
        .empty   (q_empty)
    );

    // compute the coefficient and drive the result transaction
    rpc_back #(
        .CW(CW), .SUM_W(SUM_W), .SQ_W(SQ_W), .MW(MW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop       (pop),
        .snap_n    (rd_snap[CW-1:0]),
        .snap_sa   ($signed(rd_snap[O_SA +: SUM_W])),
        .snap_sb   ($signed(rd_snap[O_SB +: SUM_W])),
        .snap_saa  ($signed(rd_snap[O_SAA +: SQ_W])),
        .snap_sbb  ($signed(rd_snap[O_SBB +: SQ_W])),
        .snap_sab  ($signed(rd_snap[O_SAB +: SQ_W])),
        .snap_ck   (rd_snap[O_CK +: KN]),
        .snap_last (rd_snap[O_LST]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_corr  (o_corr),
        .out_ck    (o_ck),
        .out_used  (o_used),
        .out_last  (m_tlast)
    );

    assign m_tdata = {o_used, o_ck, o_corr};

endmodule

`default_nettype wire
